@@ hw/rtl/dvrt_pkg.sv @@
`timescale 1ns / 1ps

package dvrt_pkg;

    localparam int DefMaxRoutes = 16;
    localparam int DefCostBits  = 16;

    localparam int ReqW     = 3;
    localparam int IdW      = 4;
    localparam int CostW    = 16;
    localparam int TotalW   = 5;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 16;

    localparam logic [IdW-1:0]   MyIdReset = 4'd0;
    localparam logic [CostW-1:0] InfReset  = 16'd999;

    typedef enum logic [ReqW-1:0] {
        REQ_CLEAR  = 3'd0,
        REQ_LOAD   = 3'd1,
        REQ_UPDATE = 3'd2,
        REQ_DEAD   = 3'd3,
        REQ_DUMP   = 3'd4
    } t_req;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MY_ID = 1'd0,
        CFG_INF   = 1'd1
    } t_cfg_idx;

endpackage

@@ hw/rtl/dvrt_ram.sv @@
`timescale 1ns / 1ps

module dvrt_ram #(
    parameter int Width = 24,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/distance_vector_route_table.sv @@
// Clear, load, unused request codes, empty dumps and updates of an aborted packet go
// to the finish state, which registers their result once the output is free. Update
// and dead-neighbor requests first scan the table one entry per cycle, an update up to
// its first match. A dump reads each entry in S_DRD and registers it from S_DOUT once the
// output is free. One transaction is worked on at a time; a stalled result holds the next
// one back. Synchronous active-low reset empties the table and clears both packet flags.
`timescale 1ns / 1ps

module distance_vector_route_table #(
    parameter int MAX_ROUTES = dvrt_pkg::DefMaxRoutes,
    parameter int COST_BITS  = dvrt_pkg::DefCostBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_we,
    input  logic [dvrt_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [dvrt_pkg::CfgDataW-1:0] i_cfg_data,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dvrt_pkg::ReqW-1:0]     i_req_type,
    input  logic [dvrt_pkg::IdW-1:0]      i_dest_id,
    input  logic [dvrt_pkg::IdW-1:0]      i_route_next_hop,
    input  logic [dvrt_pkg::CostW-1:0]    i_route_cost,
    input  logic [dvrt_pkg::IdW-1:0]      i_sender_id,
    input  logic [dvrt_pkg::CostW-1:0]    i_link_cost,
    input  logic                          i_last_in_packet,
    input  logic [dvrt_pkg::IdW-1:0]      i_dead_neighbor,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_status,
    output logic                          o_entry_changed,
    output logic                          o_packet_changed,
    output logic [dvrt_pkg::IdW-1:0]      o_out_dest,
    output logic [dvrt_pkg::IdW-1:0]      o_out_next_hop,
    output logic [dvrt_pkg::CostW-1:0]    o_out_cost,
    output logic [dvrt_pkg::TotalW-1:0]   o_route_total,
    output logic                          o_last
);

    import dvrt_pkg::*;

    localparam int AddrW = $clog2(MAX_ROUTES);
    localparam int CntW  = $clog2(MAX_ROUTES + 1);
    localparam int EntW  = 2 * IdW + COST_BITS;
    localparam logic [32:0]     CostMaxW = (33'd1 << COST_BITS) - 33'd1;
    localparam logic [CntW-1:0] MaxCnt   = CntW'(MAX_ROUTES);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_FINISH = 5'b00100,
        S_DRD    = 5'b01000,
        S_DOUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic r_chg, n_chg;
    logic r_abort, n_abort;
    logic [IdW-1:0] r_my_id, n_my_id;
    logic [CostW-1:0] r_inf_cfg, n_inf_cfg;
    logic [CntW-1:0] r_idx, n_idx;
    logic r_rvld, n_rvld;
    logic r_found, n_found;
    logic r_ec, n_ec;
    logic r_o_valid, n_o_valid;

    logic [ReqW-1:0] r_req, n_req;
    logic [IdW-1:0] r_dest, n_dest;
    logic [IdW-1:0] r_rnh, n_rnh;
    logic [IdW-1:0] r_sender, n_sender;
    logic r_lastp, n_lastp;
    logic [IdW-1:0] r_dead, n_dead;
    logic [COST_BITS-1:0] r_lcost, n_lcost;
    logic [COST_BITS-1:0] r_sum, n_sum;
    logic [AddrW-1:0] r_ridx, n_ridx;
    logic [AddrW-1:0] r_fidx, n_fidx;
    logic [IdW-1:0] r_hit_hop, n_hit_hop;
    logic [COST_BITS-1:0] r_hit_cost, n_hit_cost;

    logic r_o_status, n_o_status;
    logic r_o_ec, n_o_ec;
    logic r_o_pc, n_o_pc;
    logic [IdW-1:0] r_o_dest, n_o_dest;
    logic [IdW-1:0] r_o_hop, n_o_hop;
    logic [CostW-1:0] r_o_cost, n_o_cost;
    logic [TotalW-1:0] r_o_total, n_o_total;
    logic r_o_last, n_o_last;

    logic ram_we, ram_re;
    logic [AddrW-1:0] ram_waddr, ram_raddr;
    logic [EntW-1:0] ram_wdata, ram_rdata;
    logic [IdW-1:0] rd_dest, rd_hop;
    logic [COST_BITS-1:0] rd_cost;
    logic [COST_BITS-1:0] w_inf;
    logic [32:0] w_sum_full;
    logic in_accept, out_free, issue;
    logic f_ec, f_st, f_pc, f_cond;

    dvrt_ram #(
        .Width (EntW),
        .Depth (MAX_ROUTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_dest = ram_rdata[EntW-1 -: IdW];
    assign rd_hop  = ram_rdata[COST_BITS +: IdW];
    assign rd_cost = ram_rdata[COST_BITS-1:0];

    assign w_inf = (33'(r_inf_cfg) > CostMaxW) ? COST_BITS'(CostMaxW) : COST_BITS'(r_inf_cfg);
    assign w_sum_full = 33'(i_link_cost) + 33'(i_route_cost);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_o_valid || !i_out_stall;
    assign issue      = (r_idx < r_count);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_chg = r_chg;
        n_abort = r_abort;
        n_my_id = r_my_id;
        n_inf_cfg = r_inf_cfg;
        n_idx = r_idx;
        n_rvld = 1'b0;
        n_found = r_found;
        n_ec = r_ec;
        n_o_valid = r_o_valid && i_out_stall;
        n_req = r_req;
        n_dest = r_dest;
        n_rnh = r_rnh;
        n_sender = r_sender;
        n_lastp = r_lastp;
        n_dead = r_dead;
        n_lcost = r_lcost;
        n_sum = r_sum;
        n_ridx = r_ridx;
        n_fidx = r_fidx;
        n_hit_hop = r_hit_hop;
        n_hit_cost = r_hit_cost;
        n_o_status = r_o_status;
        n_o_ec = r_o_ec;
        n_o_pc = r_o_pc;
        n_o_dest = r_o_dest;
        n_o_hop = r_o_hop;
        n_o_cost = r_o_cost;
        n_o_total = r_o_total;
        n_o_last = r_o_last;
        ram_we = 1'b0;
        ram_waddr = r_ridx;
        ram_wdata = {rd_dest, rd_hop, w_inf};
        ram_re = 1'b0;
        ram_raddr = r_idx[AddrW-1:0];
        f_ec = 1'b0;
        f_st = 1'b0;
        f_pc = 1'b0;
        f_cond = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MY_ID: n_my_id = i_cfg_data[IdW-1:0];
                CFG_INF:   n_inf_cfg = i_cfg_data;
                default:   n_inf_cfg = r_inf_cfg;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_req = i_req_type;
                    n_dest = i_dest_id;
                    n_rnh = i_route_next_hop;
                    n_sender = i_sender_id;
                    n_lastp = i_last_in_packet;
                    n_dead = i_dead_neighbor;
                    if (i_dest_id == r_my_id) begin
                        n_lcost = '0;
                    end else if (33'(i_route_cost) > CostMaxW) begin
                        n_lcost = COST_BITS'(CostMaxW);
                    end else begin
                        n_lcost = COST_BITS'(i_route_cost);
                    end
                    n_sum = (w_sum_full > 33'(w_inf)) ? w_inf : COST_BITS'(w_sum_full);
                    n_idx = '0;
                    n_found = 1'b0;
                    n_ec = 1'b0;
                    case (i_req_type)
                        REQ_UPDATE: n_state = r_abort ? S_FINISH : S_SCAN;
                        REQ_DEAD:   n_state = S_SCAN;
                        REQ_DUMP:   n_state = (r_count == '0) ? S_FINISH : S_DRD;
                        default:    n_state = S_FINISH;
                    endcase
                end
            end

            S_SCAN: begin
                ram_re = issue;
                n_rvld = issue;
                n_ridx = r_idx[AddrW-1:0];
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (!issue && !r_rvld) begin
                    n_state = S_FINISH;
                end
                if (r_rvld) begin
                    if (r_req == REQ_UPDATE && rd_dest == r_dest) begin
                        n_found = 1'b1;
                        n_fidx = r_ridx;
                        n_hit_hop = rd_hop;
                        n_hit_cost = rd_cost;
                        n_rvld = 1'b0;
                        n_state = S_FINISH;
                    end else if (r_req == REQ_DEAD && rd_hop == r_dead) begin
                        ram_we = 1'b1;
                        if (rd_cost != w_inf) begin
                            n_ec = 1'b1;
                        end
                    end
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    case (r_req)
                        REQ_CLEAR: begin
                            n_count = '0;
                            n_chg = 1'b0;
                            n_abort = 1'b0;
                        end
                        REQ_LOAD: begin
                            if (r_count < MaxCnt) begin
                                ram_we = 1'b1;
                                ram_waddr = r_count[AddrW-1:0];
                                ram_wdata = {r_dest, r_dest, r_lcost};
                                n_count = r_count + 1'b1;
                                f_ec = 1'b1;
                            end else begin
                                f_st = 1'b1;
                            end
                        end
                        REQ_UPDATE: begin
                            if (!r_abort) begin
                                if (r_found) begin
                                    f_cond = (r_hit_hop == r_sender) ||
                                             ((r_sum < r_hit_cost) && (r_my_id != r_rnh));
                                    if (f_cond) begin
                                        ram_we = 1'b1;
                                        ram_waddr = r_fidx;
                                        ram_wdata = {r_dest, r_sender, r_sum};
                                        f_ec = (r_hit_hop != r_sender) || (r_hit_cost != r_sum);
                                    end
                                end else if (r_count < MaxCnt) begin
                                    ram_we = 1'b1;
                                    ram_waddr = r_count[AddrW-1:0];
                                    ram_wdata = {r_dest, r_sender, r_sum};
                                    n_count = r_count + 1'b1;
                                    f_ec = 1'b1;
                                end else begin
                                    n_abort = 1'b1;
                                end
                            end
                            n_chg = r_chg || f_ec;
                            f_st = n_abort;
                            if (r_lastp) begin
                                f_pc = !n_abort && n_chg;
                                n_chg = 1'b0;
                                n_abort = 1'b0;
                            end
                        end
                        REQ_DEAD: f_ec = r_ec;
                        default:  f_ec = 1'b0;
                    endcase
                    n_o_valid = 1'b1;
                    n_o_status = f_st;
                    n_o_ec = f_ec;
                    n_o_pc = f_pc;
                    n_o_dest = '0;
                    n_o_hop = '0;
                    n_o_cost = '0;
                    n_o_total = TotalW'(n_count);
                    n_o_last = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_DRD: begin
                ram_re = 1'b1;
                n_state = S_DOUT;
            end

            S_DOUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_status = 1'b0;
                    n_o_ec = 1'b0;
                    n_o_pc = 1'b0;
                    n_o_dest = rd_dest;
                    n_o_hop = rd_hop;
                    n_o_cost = CostW'(rd_cost);
                    n_o_total = TotalW'(r_count);
                    n_o_last = ((r_idx + 1'b1) == r_count);
                    n_idx = r_idx + 1'b1;
                    n_state = ((r_idx + 1'b1) == r_count) ? S_IDLE : S_DRD;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_chg <= 1'b0;
            r_abort <= 1'b0;
            r_my_id <= MyIdReset;
            r_inf_cfg <= InfReset;
            r_idx <= '0;
            r_rvld <= 1'b0;
            r_found <= 1'b0;
            r_ec <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_chg <= n_chg;
            r_abort <= n_abort;
            r_my_id <= n_my_id;
            r_inf_cfg <= n_inf_cfg;
            r_idx <= n_idx;
            r_rvld <= n_rvld;
            r_found <= n_found;
            r_ec <= n_ec;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_dest <= n_dest;
        r_rnh <= n_rnh;
        r_sender <= n_sender;
        r_lastp <= n_lastp;
        r_dead <= n_dead;
        r_lcost <= n_lcost;
        r_sum <= n_sum;
        r_ridx <= n_ridx;
        r_fidx <= n_fidx;
        r_hit_hop <= n_hit_hop;
        r_hit_cost <= n_hit_cost;
        r_o_status <= n_o_status;
        r_o_ec <= n_o_ec;
        r_o_pc <= n_o_pc;
        r_o_dest <= n_o_dest;
        r_o_hop <= n_o_hop;
        r_o_cost <= n_o_cost;
        r_o_total <= n_o_total;
        r_o_last <= n_o_last;
    end

    assign o_out_valid = r_o_valid;
    assign o_status = r_o_status;
    assign o_entry_changed = r_o_ec;
    assign o_packet_changed = r_o_pc;
    assign o_out_dest = r_o_dest;
    assign o_out_next_hop = r_o_hop;
    assign o_out_cost = r_o_cost;
    assign o_route_total = r_o_total;
    assign o_last = r_o_last;

endmodule

@@ tb/route_table_checker.sv @@
`timescale 1ns / 1ps

module route_table_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_we,
    input  logic [dvrt_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [dvrt_pkg::CfgDataW-1:0] i_cfg_data,

    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [dvrt_pkg::ReqW-1:0]     i_req_type,
    input  logic [dvrt_pkg::IdW-1:0]      i_dest_id,
    input  logic [dvrt_pkg::IdW-1:0]      i_route_next_hop,
    input  logic [dvrt_pkg::CostW-1:0]    i_route_cost,
    input  logic [dvrt_pkg::IdW-1:0]      i_sender_id,
    input  logic [dvrt_pkg::CostW-1:0]    i_link_cost,
    input  logic                          i_last_in_packet,
    input  logic [dvrt_pkg::IdW-1:0]      i_dead_neighbor,

    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_status,
    input  logic                          i_entry_changed,
    input  logic                          i_packet_changed,
    input  logic [dvrt_pkg::IdW-1:0]      i_out_dest,
    input  logic [dvrt_pkg::IdW-1:0]      i_out_next_hop,
    input  logic [dvrt_pkg::CostW-1:0]    i_out_cost,
    input  logic [dvrt_pkg::TotalW-1:0]   i_route_total,
    input  logic                          i_last,

    output int                            o_fail_count,
    output int                            o_pending
);

    import dvrt_pkg::*;

    localparam int RouteSlots = DefMaxRoutes;
    localparam int PrintCap   = 40;

    typedef struct packed {
        logic              status;
        logic              entry_changed;
        logic              packet_changed;
        logic [IdW-1:0]    dest;
        logic [IdW-1:0]    hop;
        logic [CostW-1:0]  cost;
        logic [TotalW-1:0] total;
        logic              last;
    } t_route_result;

    t_route_result     expected_route_q[$];

    logic [IdW-1:0]    tbl_dest [RouteSlots];
    logic [IdW-1:0]    tbl_hop  [RouteSlots];
    logic [CostW-1:0]  tbl_cost [RouteSlots];
    logic [TotalW-1:0] route_count;
    logic              pkt_changed_flag;
    logic              pkt_abort_flag;
    logic [IdW-1:0]    my_id;
    logic [CostW-1:0]  inf_cost;

    int mismatch_count = 0;
    int result_index   = 0;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PrintCap) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      result_index, name, got, want));
        end
    endtask

    task automatic apply_route_request(
        input logic [ReqW-1:0]  req,
        input logic [IdW-1:0]   dest,
        input logic [IdW-1:0]   rnh,
        input logic [CostW-1:0] rcost,
        input logic [IdW-1:0]   sender,
        input logic [CostW-1:0] link,
        input logic             lastp,
        input logic [IdW-1:0]   dead
    );
        t_route_result  res;
        t_route_result  entry;
        logic [CostW:0] sum;
        int             slot;
        bit             found;
        res = '0;
        res.last = 1'b1;
        slot = 0;
        found = 1'b0;
        case (req)
            REQ_CLEAR: begin
                route_count = '0;
                pkt_changed_flag = 1'b0;
                pkt_abort_flag = 1'b0;
            end
            REQ_LOAD: begin
                if (route_count < RouteSlots) begin
                    tbl_dest[route_count] = dest;
                    tbl_hop[route_count] = dest;
                    tbl_cost[route_count] = (dest == my_id) ? '0 : rcost;
                    route_count++;
                    res.entry_changed = 1'b1;
                end else begin
                    res.status = 1'b1;
                end
            end
            REQ_UPDATE: begin
                if (!pkt_abort_flag) begin
                    sum = {1'b0, link} + {1'b0, rcost};
                    if (sum > {1'b0, inf_cost}) begin
                        sum = {1'b0, inf_cost};
                    end
                    for (int k = 0; k < route_count; k++) begin
                        if (!found && tbl_dest[k] == dest) begin
                            found = 1'b1;
                            slot = k;
                        end
                    end
                    if (found) begin
                        if (tbl_hop[slot] == sender ||
                            (sum[CostW-1:0] < tbl_cost[slot] && my_id != rnh)) begin
                            if (tbl_hop[slot] != sender || tbl_cost[slot] != sum[CostW-1:0]) begin
                                res.entry_changed = 1'b1;
                            end
                            tbl_hop[slot] = sender;
                            tbl_cost[slot] = sum[CostW-1:0];
                        end
                    end else if (route_count < RouteSlots) begin
                        tbl_dest[route_count] = dest;
                        tbl_hop[route_count] = sender;
                        tbl_cost[route_count] = sum[CostW-1:0];
                        route_count++;
                        res.entry_changed = 1'b1;
                    end else begin
                        pkt_abort_flag = 1'b1;
                    end
                end
                if (res.entry_changed) begin
                    pkt_changed_flag = 1'b1;
                end
                res.status = pkt_abort_flag;
                if (lastp) begin
                    res.packet_changed = !pkt_abort_flag && pkt_changed_flag;
                    pkt_changed_flag = 1'b0;
                    pkt_abort_flag = 1'b0;
                end
            end
            REQ_DEAD: begin
                for (int k = 0; k < route_count; k++) begin
                    if (tbl_hop[k] == dead) begin
                        if (tbl_cost[k] != inf_cost) begin
                            res.entry_changed = 1'b1;
                        end
                        tbl_cost[k] = inf_cost;
                    end
                end
            end
            REQ_DUMP: begin
                if (route_count != 0) begin
                    for (int k = 0; k < route_count; k++) begin
                        entry = '0;
                        entry.dest = tbl_dest[k];
                        entry.hop = tbl_hop[k];
                        entry.cost = tbl_cost[k];
                        entry.total = route_count;
                        entry.last = (k == route_count - 1);
                        expected_route_q.push_back(entry);
                    end
                    return;
                end
            end
            default: begin
            end
        endcase
        res.total = route_count;
        expected_route_q.push_back(res);
    endtask

    task automatic check_route_result();
        t_route_result want;
        if (expected_route_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      result_index));
        end else begin
            want = expected_route_q.pop_front();
            check_field("status", 32'(i_status), 32'(want.status));
            check_field("entry_changed", 32'(i_entry_changed), 32'(want.entry_changed));
            check_field("packet_changed", 32'(i_packet_changed), 32'(want.packet_changed));
            check_field("out_dest", 32'(i_out_dest), 32'(want.dest));
            check_field("out_next_hop", 32'(i_out_next_hop), 32'(want.hop));
            check_field("out_cost", 32'(i_out_cost), 32'(want.cost));
            check_field("route_total", 32'(i_route_total), 32'(want.total));
            check_field("last", 32'(i_last), 32'(want.last));
        end
        result_index++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_route_q.delete();
            route_count = '0;
            pkt_changed_flag = 1'b0;
            pkt_abort_flag = 1'b0;
            my_id = MyIdReset;
            inf_cost = InfReset;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_route_result();
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MY_ID: my_id = i_cfg_data[IdW-1:0];
                    CFG_INF:   inf_cost = i_cfg_data[CostW-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                apply_route_request(i_req_type, i_dest_id, i_route_next_hop, i_route_cost,
                                    i_sender_id, i_link_cost, i_last_in_packet,
                                    i_dead_neighbor);
            end
        end
        o_pending <= expected_route_q.size();
    end

endmodule

@@ tb/tb_distance_vector_route_table.sv @@
`timescale 1ns / 1ps

module tb_distance_vector_route_table;
    import dvrt_pkg::*;

    localparam int CycleLimit    = 400000;
    localparam int LongHold      = 400;
    localparam int DrainCycles   = 50;
    localparam int PhaseItems    = 65;
    localparam int RandomPhases  = 6;

    localparam logic [ReqW-1:0] REQ_RSVD_FIRST = 3'd5;
    localparam logic [ReqW-1:0] REQ_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic [ReqW-1:0]  req;
        logic [IdW-1:0]   dest;
        logic [IdW-1:0]   rnh;
        logic [CostW-1:0] rcost;
        logic [IdW-1:0]   sender;
        logic [CostW-1:0] link;
        logic             lastp;
        logic [IdW-1:0]   dead;
    } t_route_req;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [ReqW-1:0]     i_req_type;
    logic [IdW-1:0]      i_dest_id;
    logic [IdW-1:0]      i_route_next_hop;
    logic [CostW-1:0]    i_route_cost;
    logic [IdW-1:0]      i_sender_id;
    logic [CostW-1:0]    i_link_cost;
    logic                i_last_in_packet;
    logic [IdW-1:0]      i_dead_neighbor;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_status;
    logic                o_entry_changed;
    logic                o_packet_changed;
    logic [IdW-1:0]      o_out_dest;
    logic [IdW-1:0]      o_out_next_hop;
    logic [CostW-1:0]    o_out_cost;
    logic [TotalW-1:0]   o_route_total;
    logic                o_last;

    int             fail_count;
    int             route_pending;
    int unsigned    cycle_count = 0;
    int             burst_left = 0;
    int             items_sent = 0;
    logic [IdW-1:0] cur_my_id = MyIdReset;
    logic           hold_off_req = 1'b0;

    always #5 i_clk = ~i_clk;

    distance_vector_route_table u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_dest_id        (i_dest_id),
        .i_route_next_hop (i_route_next_hop),
        .i_route_cost     (i_route_cost),
        .i_sender_id      (i_sender_id),
        .i_link_cost      (i_link_cost),
        .i_last_in_packet (i_last_in_packet),
        .i_dead_neighbor  (i_dead_neighbor),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_entry_changed  (o_entry_changed),
        .o_packet_changed (o_packet_changed),
        .o_out_dest       (o_out_dest),
        .o_out_next_hop   (o_out_next_hop),
        .o_out_cost       (o_out_cost),
        .o_route_total    (o_route_total),
        .o_last           (o_last)
    );

    route_table_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_dest_id        (i_dest_id),
        .i_route_next_hop (i_route_next_hop),
        .i_route_cost     (i_route_cost),
        .i_sender_id      (i_sender_id),
        .i_link_cost      (i_link_cost),
        .i_last_in_packet (i_last_in_packet),
        .i_dead_neighbor  (i_dead_neighbor),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_entry_changed  (o_entry_changed),
        .i_packet_changed (o_packet_changed),
        .i_out_dest       (o_out_dest),
        .i_out_next_hop   (o_out_next_hop),
        .i_out_cost       (o_out_cost),
        .i_route_total    (o_route_total),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_pending        (route_pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver alternates between segments of different stall density and
    // holds off once for a long stretch so that the block backs up.
    initial begin
        int       hold_left;
        int       seg_left;
        int       stall_mode;
        bit       hold_done;
        hold_left = 0;
        seg_left = 0;
        stall_mode = 0;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LongHold;
                i_out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (stall_mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= $urandom_range(0, 1);
                    default: i_out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic t_route_req make_req(
        input logic [ReqW-1:0]  req,
        input logic [IdW-1:0]   dest,
        input logic [IdW-1:0]   rnh,
        input logic [CostW-1:0] rcost,
        input logic [IdW-1:0]   sender,
        input logic [CostW-1:0] link,
        input logic             lastp,
        input logic [IdW-1:0]   dead
    );
        t_route_req rq;
        rq.req = req;
        rq.dest = dest;
        rq.rnh = rnh;
        rq.rcost = rcost;
        rq.sender = sender;
        rq.link = link;
        rq.lastp = lastp;
        rq.dead = dead;
        return rq;
    endfunction

    function automatic t_route_req random_fields();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_route_req)-1:0];
    endfunction

    function automatic logic [IdW-1:0] pick_id();
        if ($urandom_range(0, 2) == 0) begin
            return IdW'($urandom_range(0, 15));
        end
        return IdW'($urandom_range(0, 5));
    endfunction

    function automatic logic [CostW-1:0] pick_cost();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return CostW'($urandom);
            default: return CostW'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic send_req(input t_route_req rq);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rq.req;
        i_dest_id <= rq.dest;
        i_route_next_hop <= rq.rnh;
        i_route_cost <= rq.rcost;
        i_sender_id <= rq.sender;
        i_link_cost <= rq.link;
        i_last_in_packet <= rq.lastp;
        i_dead_neighbor <= rq.dead;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (route_pending != 0);
    endtask

    task automatic set_config(input logic [IdW-1:0] my_id, input logic [CostW-1:0] inf);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_MY_ID;
        i_cfg_data <= CfgDataW'(my_id);
        @(posedge i_clk);
        i_cfg_idx <= CFG_INF;
        i_cfg_data <= inf;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_my_id = my_id;
    endtask

    task automatic send_packet(input logic [IdW-1:0] sender, input int entries,
                               input bit broken);
        t_route_req rq;
        for (int k = 0; k < entries; k++) begin
            rq = random_fields();
            rq.req = REQ_UPDATE;
            rq.dest = pick_id();
            rq.rnh = ($urandom_range(0, 3) == 0) ? cur_my_id : IdW'($urandom);
            rq.rcost = pick_cost();
            rq.sender = sender;
            rq.link = pick_cost();
            rq.lastp = (k == entries - 1) && !broken;
            send_req(rq);
        end
    endtask

    task automatic send_loads(input int count);
        t_route_req rq;
        for (int k = 0; k < count; k++) begin
            rq = random_fields();
            rq.req = REQ_LOAD;
            rq.dest = ($urandom_range(0, 7) == 0) ? cur_my_id : pick_id();
            rq.rcost = pick_cost();
            send_req(rq);
        end
    endtask

    task automatic run_random(input int count);
        t_route_req rq;
        int         target;
        int         pick;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            rq = random_fields();
            if (pick < 45) begin
                send_packet(pick_id(), $urandom_range(1, 6), $urandom_range(0, 9) == 0);
            end else if (pick < 58) begin
                send_loads(1);
            end else if (pick < 68) begin
                rq.req = REQ_DEAD;
                rq.dead = pick_id();
                send_req(rq);
            end else if (pick < 78) begin
                rq.req = REQ_DUMP;
                send_req(rq);
            end else if (pick < 82) begin
                rq.req = REQ_CLEAR;
                send_req(rq);
            end else if (pick < 86) begin
                rq.req = ReqW'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
                send_req(rq);
            end else if (pick < 89) begin
                // Load the table to near or past capacity, then push a packet that may overflow it.
                rq.req = REQ_CLEAR;
                send_req(rq);
                send_loads($urandom_range(14, 17));
                send_packet(pick_id(), $urandom_range(2, 4), 1'b0);
                send_loads(1);
            end else if (pick < 93) begin
                wait_drained();
            end else begin
                send_req(rq);
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_MY_ID;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_req_type <= REQ_CLEAR;
        i_dest_id <= '0;
        i_route_next_hop <= '0;
        i_route_cost <= '0;
        i_sender_id <= '0;
        i_link_cost <= '0;
        i_last_in_packet <= 1'b0;
        i_dead_neighbor <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with the registers at their reset values.
        send_req(make_req(REQ_DUMP, 4'd0, 4'd0, 16'd0, 4'd0, 16'd0, 1'b0, 4'd0));
        send_req(make_req(REQ_RSVD_LAST, '1, '1, '1, '1, '1, 1'b1, '1));
        send_req(make_req(REQ_LOAD, 4'd0, 4'd0, 16'd500, 4'd0, 16'd0, 1'b0, 4'd0));
        send_req(make_req(REQ_LOAD, 4'd3, 4'd0, 16'hFFFF, 4'd0, 16'd0, 1'b0, 4'd0));
        send_req(make_req(REQ_LOAD, 4'd5, 4'd0, 16'd10, 4'd0, 16'd0, 1'b0, 4'd0));
        send_req(make_req(REQ_UPDATE, 4'd9, 4'd2, 16'hFFFF, 4'd5, 16'hFFFF, 1'b0, 4'd0));
        send_req(make_req(REQ_UPDATE, 4'd9, 4'd2, 16'd3, 4'd5, 16'd10, 1'b0, 4'd0));
        send_req(make_req(REQ_UPDATE, 4'd9, 4'd2, 16'd3, 4'd5, 16'd10, 1'b1, 4'd0));
        send_req(make_req(REQ_UPDATE, 4'd9, 4'd0, 16'd0, 4'd3, 16'd1, 1'b1, 4'd0));
        send_req(make_req(REQ_UPDATE, 4'd9, 4'd4, 16'd0, 4'd3, 16'd1, 1'b1, 4'd0));
        send_req(make_req(REQ_DEAD, 4'd0, 4'd0, 16'd0, 4'd0, 16'd0, 1'b0, 4'd3));
        for (int k = 0; k < 12; k++) begin
            send_req(make_req(REQ_LOAD, IdW'(k), 4'd0, CostW'(k * 7), 4'd0, 16'd0,
                              1'b0, 4'd0));
        end
        send_req(make_req(REQ_LOAD, 4'd14, 4'd0, 16'd4, 4'd0, 16'd0, 1'b0, 4'd0));
        send_req(make_req(REQ_UPDATE, 4'd15, 4'd1, 16'd2, 4'd5, 16'd2, 1'b0, 4'd0));
        send_req(make_req(REQ_UPDATE, 4'd2, 4'd1, 16'd0, 4'd5, 16'd0, 1'b1, 4'd0));
        send_req(make_req(REQ_DUMP, 4'd0, 4'd0, 16'd0, 4'd0, 16'd0, 1'b0, 4'd0));
        send_req(make_req(REQ_CLEAR, 4'd0, 4'd0, 16'd0, 4'd0, 16'd0, 1'b0, 4'd0));
        wait_drained();

        for (int ph = 0; ph < RandomPhases; ph++) begin
            case (ph)
                0:       set_config(4'd15, 16'hFFFF);
                1:       set_config(4'd0, 16'd1);
                2:       set_config(4'd7, 16'd60);
                3:       set_config(IdW'($urandom), CostW'($urandom_range(1, 65535)));
                4:       set_config(4'd9, 16'd999);
                default: set_config(IdW'($urandom), CostW'($urandom_range(1, 200)));
            endcase
            if (ph == 2) begin
                hold_off_req <= 1'b1;
            end
            run_random(PhaseItems);
            wait_drained();
        end

        repeat (DrainCycles) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && route_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/dvrt_pkg.sv
hw/rtl/dvrt_ram.sv
hw/rtl/distance_vector_route_table.sv
tb/route_table_checker.sv
tb/tb_distance_vector_route_table.sv
